// ===== rtl/aomf_pkg.sv =====
// ----------------------------------------------------------------------------
// Obstacle avoidance maneuver package
// Shared types, codes and widths for the obstacle avoidance sequencer.
// ----------------------------------------------------------------------------
package aomf_pkg;

  // Number of line sensors in use; only the low bits of the mask are looked at.
  localparam int SENSOR_BITS = 8;

  localparam int MaskW   = 8;
  localparam int DistW   = 12;
  localparam int TimeW   = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 16;
  localparam int InDataW = 40;
  localparam int OutDataW = 8;

  // Sensors that take part in line detection.
  localparam logic [MaskW-1:0] SensorMask =
    MaskW'((17'(1) << SENSOR_BITS) - 17'(1));

  // Maneuver phases.
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_STOP     = 3'd1,
    PH_LEFT     = 3'd2,
    PH_SETTLE_L = 3'd3,
    PH_FORWARD  = 3'd4,
    PH_SETTLE_F = 3'd5,
    PH_RIGHT    = 3'd6
  } phase_t;

  // Drive command codes.
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_LEFT  = 3'd2,
    CMD_FWD   = 3'd3,
    CMD_RIGHT = 3'd4
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_STOP_SET  = 3'd1,
    REG_LEFT      = 3'd2,
    REG_SETTLE    = 3'd3,
    REG_FORWARD   = 3'd4,
    REG_RIGHT_TO  = 3'd5,
    REG_REARM     = 3'd6
  } cfg_idx_t;

  // Current register values.
  typedef struct packed {
    logic [DistW-1:0] obstacle_threshold_mm;
    logic [TimeW-1:0] stop_settle_ms;
    logic [TimeW-1:0] left_shift_ms;
    logic [TimeW-1:0] shift_settle_ms;
    logic [TimeW-1:0] forward_ms;
    logic [TimeW-1:0] right_timeout_ms;
    logic [TimeW-1:0] rearm_ms;
  } cfg_t;

  // One registered input item.
  typedef struct packed {
    logic [TimeW-1:0] delta_ms;
    logic [DistW-1:0] distance_mm;
    logic [MaskW-1:0] line_mask;
  } tick_t;

  // Handshake between input stage and core.
  typedef struct packed {
    logic  valid;
    tick_t tick;
  } in_stage_t;

endpackage

// ===== rtl/obstacle_avoid_maneuver_fsm_top.sv =====
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle while out_tready does not stall the result; the phase,
// timer and cooldown registers update in the same cycle the item is stepped, so the next item sees them.
// Reset (rst_n low, synchronous) returns the sequencer to idle with zero
// timers, loads the default durations and empties both register stages.
// ----------------------------------------------------------------------------
// Obstacle avoidance maneuver sequencer, top level
// Stream in control ticks, stream out one drive command item per tick.
// ----------------------------------------------------------------------------
module obstacle_avoid_maneuver_fsm_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // Bits from 0: line_mask[7:0], distance_mm[19:8], delta_ms[35:20], zero pad.
  input  logic [aomf_pkg::InDataW-1:0]    in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Bits from 0: drive_command[2:0], active[3], phase_code[6:4], zero pad.
  output logic [aomf_pkg::OutDataW-1:0]   out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Finished flag: the maneuver ended on this item.
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [aomf_pkg::CfgIdxW-1:0]    cfg_addr,
  input  logic [aomf_pkg::CfgW-1:0]       cfg_wdata
);

  aomf_pkg::cfg_t      cfg;
  aomf_pkg::in_stage_t stage;
  logic                take;

  aomf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  aomf_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .take      (take),
    .stage     (stage)
  );

  aomf_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .stage      (stage),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/aomf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the threshold and phase durations, written through a plain port.
// ----------------------------------------------------------------------------
module aomf_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [aomf_pkg::CfgIdxW-1:0]  cfg_addr,
  input  logic [aomf_pkg::CfgW-1:0]     cfg_wdata,
  output aomf_pkg::cfg_t                cfg
);

  aomf_pkg::cfg_t cfg_r;
  aomf_pkg::cfg_t cfg_nxt;

  // Decode the write; indexes past the list leave everything unchanged.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (aomf_pkg::cfg_idx_t'(cfg_addr))
        aomf_pkg::REG_THRESHOLD:
          cfg_nxt.obstacle_threshold_mm = cfg_wdata[aomf_pkg::DistW-1:0];
        aomf_pkg::REG_STOP_SET:  cfg_nxt.stop_settle_ms   = cfg_wdata;
        aomf_pkg::REG_LEFT:      cfg_nxt.left_shift_ms    = cfg_wdata;
        aomf_pkg::REG_SETTLE:    cfg_nxt.shift_settle_ms  = cfg_wdata;
        aomf_pkg::REG_FORWARD:   cfg_nxt.forward_ms       = cfg_wdata;
        aomf_pkg::REG_RIGHT_TO:  cfg_nxt.right_timeout_ms = cfg_wdata;
        aomf_pkg::REG_REARM:     cfg_nxt.rearm_ms         = cfg_wdata;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  // Register bank with its reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.obstacle_threshold_mm <= 12'd50;
      cfg_r.stop_settle_ms        <= 16'd200;
      cfg_r.left_shift_ms         <= 16'd600;
      cfg_r.shift_settle_ms       <= 16'd200;
      cfg_r.forward_ms            <= 16'd800;
      cfg_r.right_timeout_ms      <= 16'd3000;
      cfg_r.rearm_ms              <= 16'd1000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/aomf_in_stage.sv =====
// ----------------------------------------------------------------------------
// Input register stage
// Captures one tick item and holds it until the core can take it.
// ----------------------------------------------------------------------------
module aomf_in_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [aomf_pkg::InDataW-1:0]    in_tdata,
  input  logic                            take,
  output aomf_pkg::in_stage_t             stage
);

  logic            valid_r;
  logic            valid_nxt;
  aomf_pkg::tick_t tick_r;
  logic            load;

  // The slot frees up whenever the core takes the held item.
  assign in_tready = !valid_r || take;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  // Control bit gets reset; payload is only loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tick_r.line_mask   <= in_tdata[7:0];
      tick_r.distance_mm <= in_tdata[19:8];
      tick_r.delta_ms    <= in_tdata[35:20];
    end
  end

  assign stage.valid = valid_r;
  assign stage.tick  = tick_r;

endmodule

// ===== rtl/aomf_core.sv =====
// ----------------------------------------------------------------------------
// Maneuver sequencer core
// Steps the phase state machine once per item and registers the result.
// ----------------------------------------------------------------------------
module aomf_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  aomf_pkg::cfg_t                   cfg,
  input  aomf_pkg::in_stage_t              stage,
  output logic                             take,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [aomf_pkg::OutDataW-1:0]    out_tdata,
  output logic                             out_tlast
);

  aomf_pkg::phase_t phase_r, phase_nxt;
  logic [aomf_pkg::TimeW-1:0] time_r, time_nxt;
  logic [aomf_pkg::TimeW-1:0] cool_r, cool_nxt;
  logic white_seen_r, white_seen_nxt;

  logic out_v_r, out_v_nxt;
  aomf_pkg::cmd_t   cmd_r, cmd_nxt;
  aomf_pkg::phase_t oph_r;
  logic fin_r, fin_nxt;

  logic [aomf_pkg::MaskW-1:0] mask;
  logic [aomf_pkg::TimeW-1:0] el;
  logic [aomf_pkg::TimeW-1:0] cool_dec;
  logic trigger;
  aomf_pkg::phase_t ph_cur;
  logic [aomf_pkg::TimeW-1:0] time_base;
  logic [aomf_pkg::TimeW:0]   tsum;
  logic [aomf_pkg::TimeW-1:0] tsat;
  logic white_now;

  // The core takes an item when the result register is free or draining.
  assign take = stage.valid && (!out_v_r || out_tready);

  assign mask = stage.tick.line_mask & aomf_pkg::SensorMask;
  assign el   = stage.tick.delta_ms;

  // Cooldown count and trigger check.
  assign cool_dec = (cool_r > el) ? (cool_r - el) : '0;
  assign trigger  = (phase_r == aomf_pkg::PH_IDLE) && (cool_dec == '0) &&
                    (stage.tick.distance_mm != '0) &&
                    (stage.tick.distance_mm < cfg.obstacle_threshold_mm);
  assign ph_cur   = trigger ? aomf_pkg::PH_STOP : phase_r;

  // Time in phase, saturating at the counter's full scale.
  assign time_base = trigger ? '0 : time_r;
  assign tsum = {1'b0, time_base} + {1'b0, el};
  assign tsat = tsum[aomf_pkg::TimeW] ? '1 : tsum[aomf_pkg::TimeW-1:0];
  assign white_now = (mask == '0);

  // Next state and result for the item in the input register.
  always_comb begin
    phase_nxt      = phase_r;
    time_nxt       = time_r;
    cool_nxt       = cool_r;
    white_seen_nxt = white_seen_r;
    cmd_nxt        = aomf_pkg::CMD_NONE;
    fin_nxt        = 1'b0;
    if (take) begin
      cool_nxt = cool_dec;
      if (ph_cur != aomf_pkg::PH_IDLE) begin
        phase_nxt = ph_cur;
        time_nxt  = tsat;
        cmd_nxt   = aomf_pkg::CMD_STOP;
        case (ph_cur)
          aomf_pkg::PH_STOP: begin
            if (tsat >= cfg.stop_settle_ms) begin
              phase_nxt = aomf_pkg::PH_LEFT;
              time_nxt  = '0;
            end
          end
          aomf_pkg::PH_LEFT: begin
            if (tsat >= cfg.left_shift_ms) begin
              phase_nxt = aomf_pkg::PH_SETTLE_L;
              time_nxt  = '0;
            end else begin
              cmd_nxt = aomf_pkg::CMD_LEFT;
            end
          end
          aomf_pkg::PH_SETTLE_L: begin
            if (tsat >= cfg.shift_settle_ms) begin
              phase_nxt = aomf_pkg::PH_FORWARD;
              time_nxt  = '0;
            end
          end
          aomf_pkg::PH_FORWARD: begin
            if (tsat >= cfg.forward_ms) begin
              phase_nxt = aomf_pkg::PH_SETTLE_F;
              time_nxt  = '0;
            end else begin
              cmd_nxt = aomf_pkg::CMD_FWD;
            end
          end
          aomf_pkg::PH_SETTLE_F: begin
            if (tsat >= cfg.shift_settle_ms) begin
              white_seen_nxt = white_now;
              phase_nxt      = aomf_pkg::PH_RIGHT;
              time_nxt       = '0;
            end
          end
          aomf_pkg::PH_RIGHT: begin
            white_seen_nxt = white_seen_r || white_now;
            if ((white_seen_nxt && !white_now) || (tsat >= cfg.right_timeout_ms)) begin
              phase_nxt = aomf_pkg::PH_IDLE;
              time_nxt  = '0;
              cool_nxt  = cfg.rearm_ms;
              fin_nxt   = 1'b1;
            end else begin
              cmd_nxt = aomf_pkg::CMD_RIGHT;
            end
          end
          default: begin
            // Unused phase code: stop and fall back to idle.
            phase_nxt = aomf_pkg::PH_IDLE;
            time_nxt  = '0;
          end
        endcase
      end
    end
  end

  // Result register valid bit.
  always_comb begin
    out_v_nxt = out_v_r;
    if (take) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= aomf_pkg::PH_IDLE;
      time_r       <= '0;
      cool_r       <= '0;
      white_seen_r <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      time_r       <= time_nxt;
      cool_r       <= cool_nxt;
      white_seen_r <= white_seen_nxt;
      out_v_r      <= out_v_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= cmd_nxt;
      fin_r <= fin_nxt;
      oph_r <= phase_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = fin_r;
  assign out_tdata  = {1'b0, oph_r, (oph_r != aomf_pkg::PH_IDLE), cmd_r};

endmodule

// ===== rtl/aomf_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level's ports for result items that break the sequencer.
// ----------------------------------------------------------------------------
module aomf_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [aomf_pkg::OutDataW-1:0]   out_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            out_tlast
);

  // A finishing item always commands stop and leaves the sequencer idle.
  a_finish_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |->
      out_tdata[2:0] == aomf_pkg::CMD_STOP && out_tdata[6:4] == aomf_pkg::PH_IDLE)
    else $error("finishing item is not a stop into idle");

  // The active flag follows the reported phase.
  a_active_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3] == (out_tdata[6:4] != aomf_pkg::PH_IDLE))
    else $error("active flag disagrees with phase");

  // The shift right command only appears in the right phase.
  a_cmd_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == aomf_pkg::CMD_RIGHT |->
      out_tdata[6:4] == aomf_pkg::PH_RIGHT)
    else $error("shift right outside the right phase");

  // A stalled item holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result item changed");

endmodule

bind obstacle_avoid_maneuver_fsm_top aomf_checker u_aomf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tlast  (out_tlast)
);

// ===== tb/tb_obstacle_avoid_maneuver_fsm_top.sv =====
// ----------------------------------------------------------------------------
// Obstacle avoidance maneuver sequencer testbench
// Streams control ticks into the sequencer and predicts the drive command,
// the finished flag, the active flag and the phase for every tick. Each result
// item is compared with the oldest prediction. The register settings cover the
// defaults, all-zero durations, all-maximum durations, a zero threshold and
// several random settings. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_obstacle_avoid_maneuver_fsm_top;
  import aomf_pkg::*;

  // Cycles to let pass after the last result before a register write or the end.
  localparam int SETTLE_CYCLES = 6;
  // Cycles without any accepted item before the run is declared hung.
  localparam int HANG_LIMIT = 2000;
  // Register index past the end of the list; writes to it must be ignored.
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

  // One predicted result item.
  typedef struct {
    cmd_t   cmd;
    bit     finished;
    bit     active;
    phase_t phase;
  } drive_result_t;

  // Tracks the sequencer state, predicts each tick and holds pending results.
  class maneuver_tracker;
    cfg_t             regs;
    phase_t           phase;
    logic [TimeW-1:0] phase_ms;
    logic [TimeW-1:0] cool_left_ms;
    bit               white_seen;
    drive_result_t    drive_q[$];

    function new();
      regs.obstacle_threshold_mm = 12'd50;
      regs.stop_settle_ms        = 16'd200;
      regs.left_shift_ms         = 16'd600;
      regs.shift_settle_ms       = 16'd200;
      regs.forward_ms            = 16'd800;
      regs.right_timeout_ms      = 16'd3000;
      regs.rearm_ms              = 16'd1000;
      phase        = PH_IDLE;
      phase_ms     = '0;
      cool_left_ms = '0;
      white_seen   = 1'b0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
      case (idx)
        REG_THRESHOLD: regs.obstacle_threshold_mm = val[DistW-1:0];
        REG_STOP_SET:  regs.stop_settle_ms = val;
        REG_LEFT:      regs.left_shift_ms = val;
        REG_SETTLE:    regs.shift_settle_ms = val;
        REG_FORWARD:   regs.forward_ms = val;
        REG_RIGHT_TO:  regs.right_timeout_ms = val;
        REG_REARM:     regs.rearm_ms = val;
        default: ;
      endcase
    endfunction

    function void enter(phase_t p);
      phase    = p;
      phase_ms = '0;
    endfunction

    // Step the sequencer by one tick and queue the result it produces.
    function void note_tick(tick_t t);
      logic [MaskW-1:0] mask;
      logic [TimeW:0]   sum;
      drive_result_t    r;
      mask       = t.line_mask & SensorMask;
      r.cmd      = CMD_NONE;
      r.finished = 1'b0;

      // The cooldown runs down whatever the phase.
      if (cool_left_ms > t.delta_ms) cool_left_ms = cool_left_ms - t.delta_ms;
      else cool_left_ms = '0;

      if (phase == PH_IDLE && cool_left_ms == 0 && t.distance_mm != 0 &&
          t.distance_mm < regs.obstacle_threshold_mm) begin
        enter(PH_STOP);
      end

      if (phase != PH_IDLE) begin
        sum      = {1'b0, phase_ms} + {1'b0, t.delta_ms};
        phase_ms = sum[TimeW] ? '1 : sum[TimeW-1:0];
        case (phase)
          PH_STOP: begin
            if (phase_ms >= regs.stop_settle_ms) enter(PH_LEFT);
            r.cmd = CMD_STOP;
          end
          PH_LEFT: begin
            if (phase_ms >= regs.left_shift_ms) begin
              enter(PH_SETTLE_L);
              r.cmd = CMD_STOP;
            end else begin
              r.cmd = CMD_LEFT;
            end
          end
          PH_SETTLE_L: begin
            if (phase_ms >= regs.shift_settle_ms) enter(PH_FORWARD);
            r.cmd = CMD_STOP;
          end
          PH_FORWARD: begin
            if (phase_ms >= regs.forward_ms) begin
              enter(PH_SETTLE_F);
              r.cmd = CMD_STOP;
            end else begin
              r.cmd = CMD_FWD;
            end
          end
          PH_SETTLE_F: begin
            if (phase_ms >= regs.shift_settle_ms) begin
              white_seen = (mask == 0);
              enter(PH_RIGHT);
            end
            r.cmd = CMD_STOP;
          end
          PH_RIGHT: begin
            if (mask == 0) white_seen = 1'b1;
            if ((white_seen && mask != 0) || phase_ms >= regs.right_timeout_ms) begin
              enter(PH_IDLE);
              cool_left_ms = regs.rearm_ms;
              r.finished   = 1'b1;
              r.cmd        = CMD_STOP;
            end else begin
              r.cmd = CMD_RIGHT;
            end
          end
          default: begin
            enter(PH_IDLE);
            r.cmd = CMD_STOP;
          end
        endcase
      end

      r.active = (phase != PH_IDLE);
      r.phase  = phase;
      drive_q.push_back(r);
    endfunction

    // Compare one result item with the oldest prediction; empty string on match.
    function string check_drive(logic [OutDataW-1:0] data, logic last);
      drive_result_t e;
      string msg = "";
      if (drive_q.size() == 0) return "result item with no tick pending";
      e = drive_q.pop_front();
      if (data[2:0] !== e.cmd)
        msg = {msg, $sformatf(" drive_command got %0d want %0d", data[2:0], e.cmd)};
      if (data[3] !== e.active)
        msg = {msg, $sformatf(" active got %0b want %0b", data[3], e.active)};
      if (data[6:4] !== e.phase)
        msg = {msg, $sformatf(" phase_code got %0d want %0d", data[6:4], e.phase)};
      if (data[7] !== 1'b0)
        msg = {msg, " pad bit set"};
      if (last !== e.finished)
        msg = {msg, $sformatf(" finished got %0b want %0b", last, e.finished)};
      return msg;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [InDataW-1:0]    in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OutDataW-1:0]   out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CfgIdxW-1:0]    cfg_addr = '0;
  logic [CfgW-1:0]       cfg_wdata = '0;

  maneuver_tracker book;
  int errors;
  int idle_cycles;
  int send_calm;
  int recv_calm;
  int result_count;

  obstacle_avoid_maneuver_fsm_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    errors++;
    $display("MISMATCH at result %0d:%s", result_count, msg);
  endtask

  // Wait count for one item: mostly random, with occasional runs of no waiting.
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 1) ? 0 : $urandom_range(1, 16);
  endfunction

  function automatic tick_t tick_of(logic [MaskW-1:0] m, logic [DistW-1:0] d,
                                    logic [TimeW-1:0] e);
    tick_t t;
    t.line_mask   = m;
    t.distance_mm = d;
    t.delta_ms    = e;
    return t;
  endfunction

  // Random tick; while idle most readings are close enough to start a maneuver.
  function automatic tick_t random_tick(int el_max);
    tick_t t;
    int    thr;
    int    r;
    thr = book.regs.obstacle_threshold_mm;
    if (book.phase == PH_IDLE && thr > 1 && $urandom_range(0, 99) < 75)
      t.distance_mm = DistW'($urandom_range(1, thr - 1));
    else if ($urandom_range(0, 9) == 0)
      t.distance_mm = '0;
    else
      t.distance_mm = DistW'($urandom);
    r = $urandom_range(0, 99);
    if (r < 4) t.delta_ms = '0;
    else if (r < 8) t.delta_ms = '1;
    else if (r < 15) t.delta_ms = TimeW'($urandom);
    else t.delta_ms = TimeW'($urandom_range(0, el_max));
    t.line_mask = ($urandom_range(0, 9) < 4) ? '0 : MaskW'($urandom);
    return t;
  endfunction

  // Offer one tick and hold it until the sequencer takes it.
  task automatic send_tick(tick_t t);
    logic [InDataW-1:0] word;
    int gap;
    word = '0;
    word[$bits(tick_t)-1:0] = t;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    book.note_tick(t);
  endtask

  // Stop sending and wait until every predicted result has arrived.
  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    while (book.drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    book.write_reg(idx, val);
  endtask

  // Load a full register setting after every pending result has drained.
  task automatic set_regs(logic [CfgW-1:0] thr, logic [CfgW-1:0] stop_ms,
                          logic [CfgW-1:0] left_ms, logic [CfgW-1:0] settle_ms,
                          logic [CfgW-1:0] fwd_ms, logic [CfgW-1:0] right_ms,
                          logic [CfgW-1:0] rearm_ms);
    pause_until_drained();
    write_reg(REG_UNUSED, CfgW'($urandom));
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_STOP_SET, stop_ms);
    write_reg(REG_LEFT, left_ms);
    write_reg(REG_SETTLE, settle_ms);
    write_reg(REG_FORWARD, fwd_ms);
    write_reg(REG_RIGHT_TO, right_ms);
    write_reg(REG_REARM, rearm_ms);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int count, int el_max);
    repeat (count) begin
      send_tick(random_tick(el_max));
      if ($urandom_range(0, 99) == 0) pause_until_drained();
    end
  endtask

  // Result side: stall at random, then take and check one item.
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      begin
        string msg;
        msg = book.check_drive(out_tdata, out_tlast);
        if (msg != "") report_mismatch(msg);
        result_count++;
      end
    end
  end

  // Hang detection: no item moving on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    book = new();
    errors = 0;
    result_count = 0;
    send_calm = 0;
    recv_calm = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk with the reset settings.
    send_tick(tick_of(8'h00, 12'd0, 16'd0));        // invalid reading
    send_tick(tick_of(8'hFF, 12'd4095, 16'hFFFF));  // far reading
    send_tick(tick_of(8'h00, 12'd50, 16'd100));     // equal to threshold
    send_tick(tick_of(8'h00, 12'd49, 16'd0));       // trigger, stop held
    send_tick(tick_of(8'h00, 12'd49, 16'd199));
    send_tick(tick_of(8'h00, 12'd0, 16'd1));        // stop ends
    send_tick(tick_of(8'h00, 12'd0, 16'd599));      // still shifting left
    send_tick(tick_of(8'h00, 12'd0, 16'd1));        // left ends with stop
    send_tick(tick_of(8'h00, 12'd0, 16'hFFFF));
    send_tick(tick_of(8'h00, 12'd0, 16'hFFFF));     // forward ends with stop
    send_tick(tick_of(8'h01, 12'd0, 16'hFFFF));     // enter right on black
    send_tick(tick_of(8'h80, 12'd0, 16'd10));       // black without white first
    send_tick(tick_of(8'h00, 12'd0, 16'd10));       // white seen
    send_tick(tick_of(8'h10, 12'd0, 16'd10));       // line found, finished
    send_tick(tick_of(8'h00, 12'd1, 16'd500));      // cooldown blocks trigger
    send_tick(tick_of(8'h00, 12'd1, 16'd499));
    send_tick(tick_of(8'h00, 12'd1, 16'd1));        // cooldown over, trigger
    send_tick(tick_of(8'h00, 12'd0, 16'hFFFF));
    send_tick(tick_of(8'h00, 12'd0, 16'hFFFF));
    send_tick(tick_of(8'h00, 12'd0, 16'hFFFF));
    send_tick(tick_of(8'h00, 12'd0, 16'hFFFF));
    send_tick(tick_of(8'h00, 12'd0, 16'hFFFF));     // enter right on white
    send_tick(tick_of(8'h00, 12'd0, 16'hFFFF));     // timeout, finished

    // Widest threshold through the upper data bits, zero durations.
    set_regs(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random(100, 20);

    // Longest durations and cooldown.
    set_regs(16'd4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(100, 65535);

    // Zero threshold: nothing may start.
    set_regs(16'd0, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5);
    run_random(40, 200);

    // Random settings of moderate size.
    n = 0;
    repeat (4) begin
      set_regs({4'($urandom), 12'($urandom_range(100, 4095))},
               CfgW'($urandom_range(0, 400)), CfgW'($urandom_range(0, 400)),
               CfgW'($urandom_range(0, 400)), CfgW'($urandom_range(0, 400)),
               CfgW'($urandom_range(0, 800)), CfgW'($urandom_range(0, 600)));
      run_random(160, $urandom_range(10, 200));
      n++;
    end

    pause_until_drained();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
